[src/bafmt_pkg.sv]
// Shared types, codes and constant tables of the binary to ASCII formatter.
// Used by bafmt_ctrl, bafmt_dp and binary_to_ascii_formatter_top.
package bafmt_pkg;

   localparam int VALUE_W  = 64;
   localparam int CMD_W    = 3;
   localparam int CHAR_W   = 7;
   localparam int DEC_W    = 32;
   localparam int POW_W    = 30;
   localparam int IDX_W    = 4;
   localparam int CNT_W    = 4;
   localparam int REQ_TDATA_W = 64;
   localparam int RSP_TDATA_W = 8;

   localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'h30;
   localparam logic [CHAR_W-1:0] CHAR_A    = 7'h41;

   // Power-of-ten index of the top digit for each decimal width
   localparam logic [IDX_W-1:0] IDX_TOP_DEC32 = 4'd0;
   localparam logic [IDX_W-1:0] IDX_TOP_DEC16 = 4'd5;
   localparam logic [IDX_W-1:0] IDX_UNITS     = 4'd9;

   // Largest digit one subtraction run may produce
   localparam logic [CNT_W-1:0] DIGIT_MAX = 4'd9;

   typedef enum logic [CMD_W-1:0] {
      FMT_HEX8  = 3'd0,
      FMT_HEX16 = 3'd1,
      FMT_HEX32 = 3'd2,
      FMT_HEX64 = 3'd3,
      FMT_DEC16 = 3'd4,
      FMT_DEC32 = 3'd5
   } fmt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEX,
      ST_DEC_SKIP,
      ST_DEC_SUB,
      ST_DEC_EMIT
   } state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic load;
      logic hex_emit;
      logic idx_inc;
      logic sub;
      logic dec_emit;
   } ctl_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic out_free;
      logic hex_done;
      logic below;
      logic idx_last;
      logic digit_full;
   } dp_sts_type;

   function automatic logic [POW_W-1:0] pow10(input logic [IDX_W-1:0] idx);
      logic [POW_W-1:0] p;
      unique case (idx)
         4'd0:    p = 30'd1000000000;
         4'd1:    p = 30'd100000000;
         4'd2:    p = 30'd10000000;
         4'd3:    p = 30'd1000000;
         4'd4:    p = 30'd100000;
         4'd5:    p = 30'd10000;
         4'd6:    p = 30'd1000;
         4'd7:    p = 30'd100;
         4'd8:    p = 30'd10;
         default: p = 30'd1;
      endcase
      return p;
   endfunction

   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] c;
      if (nib < 4'd10) begin
         c = CHAR_ZERO + {3'b000, nib};
      end else begin
         c = CHAR_A + {3'b000, nib - 4'd10};
      end
      return c;
   endfunction

endpackage

[src/bafmt_ctrl.sv]
// Controller of the binary to ASCII formatter: sequences hex and decimal runs.
// Depends on bafmt_pkg; drives the commands of bafmt_dp.
module bafmt_ctrl
   import bafmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [CMD_W-1:0]    req_cmd,
   output logic                req_ready,
   input  dp_sts_type          sts,
   output ctl_cmd_type         cmd
);

   state_type state_ff, state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               priority case (req_cmd)
                  FMT_HEX8, FMT_HEX16, FMT_HEX32, FMT_HEX64: state_in = ST_HEX;
                  FMT_DEC16, FMT_DEC32:                      state_in = ST_DEC_SKIP;
                  default:                                   state_in = ST_IDLE;
               endcase
            end
         end
         ST_HEX: begin
            if (sts.out_free) begin
               cmd.hex_emit = 1'b1;
               if (sts.hex_done) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_DEC_SKIP: begin
            // drop leading zeros; a zero value runs down to the units digit
            if (!sts.idx_last && sts.below) begin
               cmd.idx_inc = 1'b1;
            end else begin
               state_in = ST_DEC_SUB;
            end
         end
         ST_DEC_SUB: begin
            if (!sts.below && !sts.digit_full) begin
               cmd.sub = 1'b1;
            end else begin
               state_in = ST_DEC_EMIT;
            end
         end
         ST_DEC_EMIT: begin
            if (sts.out_free) begin
               cmd.dec_emit = 1'b1;
               state_in = sts.idx_last ? ST_IDLE : ST_DEC_SUB;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

[src/bafmt_dp.sv]
// Datapath of the binary to ASCII formatter: value shifter, decimal
// subtractor and the output register. Depends on bafmt_pkg.
module bafmt_dp
   import bafmt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic [CMD_W-1:0]    req_cmd,
   input  logic [VALUE_W-1:0]  req_value,
   input  ctl_cmd_type         cmd,
   output dp_sts_type          sts,
   output logic                rsp_valid,
   output logic [CHAR_W-1:0]   rsp_char,
   output logic                rsp_last,
   input  logic                rsp_ready
);

   logic [VALUE_W-1:0] shift_ff, shift_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [CNT_W-1:0]   digit_ff, digit_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   logic [DEC_W-1:0]   pow_w;
   logic [DEC_W-1:0]   dec_w;

   assign pow_w = {2'b00, pow10(idx_ff)};
   assign dec_w = shift_ff[DEC_W-1:0];

   // Status toward the controller
   assign sts.out_free   = !valid_ff || rsp_ready;
   assign sts.hex_done   = (cnt_ff == '0);
   assign sts.below      = (dec_w < pow_w);
   assign sts.idx_last   = (idx_ff == IDX_UNITS);
   assign sts.digit_full = (digit_ff == DIGIT_MAX);

   // Working registers: load, shift out nibbles, subtract powers of ten
   always_comb begin
      shift_in = shift_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      digit_in = digit_ff;
      if (cmd.load) begin
         digit_in = '0;
         cnt_in   = '0;
         idx_in   = IDX_TOP_DEC32;
         shift_in = '0;
         priority case (req_cmd)
            FMT_HEX8: begin
               shift_in = {req_value[7:0], 56'd0};
               cnt_in   = 4'd1;
            end
            FMT_HEX16: begin
               shift_in = {req_value[15:0], 48'd0};
               cnt_in   = 4'd3;
            end
            FMT_HEX32: begin
               shift_in = {req_value[31:0], 32'd0};
               cnt_in   = 4'd7;
            end
            FMT_HEX64: begin
               shift_in = req_value;
               cnt_in   = 4'd15;
            end
            FMT_DEC16: begin
               shift_in = {48'd0, req_value[15:0]};
               idx_in   = IDX_TOP_DEC16;
            end
            FMT_DEC32: begin
               shift_in = {32'd0, req_value[31:0]};
               idx_in   = IDX_TOP_DEC32;
            end
            default: begin
               shift_in = '0;
            end
         endcase
      end else if (cmd.hex_emit) begin
         shift_in = {shift_ff[VALUE_W-5:0], 4'h0};
         cnt_in   = cnt_ff - 4'd1;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 4'd1;
      end else if (cmd.sub) begin
         shift_in = {32'd0, dec_w - pow_w};
         digit_in = digit_ff + 4'd1;
      end else if (cmd.dec_emit) begin
         idx_in   = idx_ff + 4'd1;
         digit_in = '0;
      end
   end

   // Output register: load a character, drop it when taken
   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      last_in  = last_ff;
      if (cmd.hex_emit) begin
         valid_in = 1'b1;
         char_in  = hex_char(shift_ff[VALUE_W-1:VALUE_W-4]);
         last_in  = sts.hex_done;
      end else if (cmd.dec_emit) begin
         valid_in = 1'b1;
         char_in  = CHAR_ZERO + {3'b000, digit_ff};
         last_in  = sts.idx_last;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      cnt_ff   <= cnt_in;
      idx_ff   <= idx_in;
      digit_ff <= digit_in;
      char_ff  <= char_in;
      last_ff  <= last_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_char  = char_ff;
   assign rsp_last  = last_ff;

endmodule

[src/binary_to_ascii_formatter_top.sv]
// Binary to ASCII formatter: formats an unsigned value as hex or decimal
// text, one character per output item. Uses bafmt_pkg, bafmt_ctrl, bafmt_dp.
//
// Usage:
//   Input channel req_*: tuser carries the format (0 hex8, 1 hex16, 2 hex32,
//   3 hex64, 4 dec16, 5 dec32), tdata the 64-bit value. Bits above the chosen
//   width are ignored; formats 6 and 7 are accepted and produce nothing.
//   Output channel rsp_*: tdata[6:0] is the ASCII character, tlast marks the
//   final character of the value's text.
//   Hex gives 2, 4, 8 or 16 upper-case digits with leading zeros; decimal
//   drops leading zeros and gives a single '0' for zero.
// Timing:
//   One item is worked on at a time; req_tready is high only while idle.
//   After accept the sequencer enters its hex state, which loads each character
//   into the output register, one per cycle while the receiver takes them.
//   Decimal digits come from a subtract loop on the current power of ten:
//   the leading-zero skip steps down the powers, then each digit is counted
//   by repeated subtraction and then loaded into the output register.
//   A stalled receiver holds the output register and the sequencer waits.
//   Reset (synchronous) returns to idle and drops any pending character.
module binary_to_ascii_formatter_top
   import bafmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [63:0] value
   input  logic [CMD_W-1:0]       req_tuser,   // [2:0] cmd
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // [6:0] char_code, [7] zero
   output logic                   rsp_tlast
);

   ctl_cmd_type       cmd;
   dp_sts_type        sts;
   logic [CHAR_W-1:0] rsp_char;

   bafmt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   bafmt_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_cmd   (req_tuser),
      .req_value (req_tdata),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_tvalid),
      .rsp_char  (rsp_char),
      .rsp_last  (rsp_tlast),
      .rsp_ready (rsp_tready)
   );

   assign rsp_tdata = {1'b0, rsp_char};

endmodule

[sim/binary_to_ascii_formatter_checker.sv]
// Checker for the binary to ASCII formatter: predicts the text of each item on
// the request channel and compares every character on the response channel.
// Depends on bafmt_pkg for widths and format codes.
`timescale 1ns / 100ps

module binary_to_ascii_formatter_checker
   import bafmt_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [63:0] value
   input  logic [CMD_W-1:0]       req_tuser,   // [2:0] cmd
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,   // [6:0] char_code, [7] zero
   input  logic                   rsp_tlast,
   output int unsigned            fail_count,
   output int unsigned            chars_pending,
   output int unsigned            items_seen,
   output int unsigned            chars_seen
);

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } text_char_type;

   localparam string DIGIT_GLYPHS = "0123456789ABCDEF";

   // Characters still owed by the formatter, oldest first
   text_char_type text_q[$];

   task automatic report(input string msg);
      fail_count++;
      if (fail_count <= 40) begin
         $display("%0t ns  mismatch: %s", $time, msg);
      end
   endtask

   function automatic logic [CHAR_W-1:0] glyph(input logic [3:0] digit);
      byte g;
      g = DIGIT_GLYPHS[digit];
      return g[CHAR_W-1:0];
   endfunction

   // Power of ten for digit position idx, position 0 being 10^9
   function automatic logic [31:0] ten_pow(input int idx);
      logic [31:0] p;
      p = 32'd1;
      repeat (9 - idx) p = p * 32'd10;
      return p;
   endfunction

   function automatic void push_char(input logic [CHAR_W-1:0] code, input logic last);
      text_char_type c;
      c.code = code;
      c.last = last;
      text_q.push_back(c);
   endfunction

   // Append the expected text for one request item
   function automatic void predict_text(input logic [CMD_W-1:0] fmt,
                                        input logic [VALUE_W-1:0] value);
      int          ndig;
      int          top;
      int          i;
      logic [31:0] rest;
      logic [3:0]  digit;
      ndig = 0;
      top  = -1;
      case (fmt)
         FMT_HEX8:  ndig = 2;
         FMT_HEX16: ndig = 4;
         FMT_HEX32: ndig = 8;
         FMT_HEX64: ndig = 16;
         FMT_DEC16: top  = 5;
         FMT_DEC32: top  = 0;
         default: ;
      endcase
      // hex: fixed digit count, so bits above the width never get looked at
      for (i = 0; i < ndig; i++) begin
         push_char(glyph(value[4*(ndig-1-i) +: 4]), i == ndig - 1);
      end
      // decimal: skip leading zeros, then count subtractions per power
      if (top >= 0) begin
         rest = (top == 5) ? {16'h0000, value[15:0]} : value[31:0];
         if (rest == 32'd0) begin
            push_char(glyph(4'd0), 1'b1);
         end else begin
            i = top;
            while (i < 9 && rest < ten_pow(i)) i++;
            for (; i < 10; i++) begin
               digit = 4'd0;
               while (rest >= ten_pow(i) && digit < 4'd9) begin
                  rest  = rest - ten_pow(i);
                  digit = digit + 4'd1;
               end
               push_char(glyph(digit), i == 9);
            end
         end
      end
   endfunction

   // Compare responses first, then queue the text of a newly accepted item
   always @(posedge clock) begin
      text_char_type want;
      if (reset) begin
         fail_count = 0;
         items_seen = 0;
         chars_seen = 0;
         chars_pending <= 0;
         text_q.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            chars_seen++;
            if (text_q.size() == 0) begin
               report($sformatf("character 0x%02h last=%0b with none expected",
                                rsp_tdata, rsp_tlast));
            end else begin
               want = text_q.pop_front();
               if (rsp_tdata[CHAR_W-1:0] !== want.code) begin
                  report($sformatf("char 0x%02h, expected 0x%02h",
                                   rsp_tdata[CHAR_W-1:0], want.code));
               end
               if (rsp_tdata[RSP_TDATA_W-1:CHAR_W] !== '0) begin
                  report($sformatf("pad bits of tdata 0x%02h not zero", rsp_tdata));
               end
               if (rsp_tlast !== want.last) begin
                  report($sformatf("tlast %0b, expected %0b on char 0x%02h",
                                   rsp_tlast, want.last, want.code));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            items_seen++;
            predict_text(req_tuser, req_tdata);
         end
         chars_pending <= text_q.size();
      end
   end

endmodule

[sim/binary_to_ascii_formatter_top_tb.sv]
// Testbench top for the binary to ASCII formatter: clock, reset, request
// stimulus, response back-pressure and the verdict. Depends on bafmt_pkg,
// binary_to_ascii_formatter_top and binary_to_ascii_formatter_checker.
`timescale 1ns / 100ps

module binary_to_ascii_formatter_top_tb;
   import bafmt_pkg::*;

   localparam logic [CMD_W-1:0] FMT_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] FMT_SPARE_HI = 3'd7;
   localparam int RANDOM_ITEMS = 128;
   localparam int TAIL_CYCLES  = 150;
   localparam int CYCLE_LIMIT  = 400000;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [CMD_W-1:0]       req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tlast;

   int unsigned fail_count;
   int unsigned chars_pending;
   int unsigned items_seen;
   int unsigned chars_seen;
   int unsigned cycle_count = 0;
   int          ready_hold  = 0;
   bit          quiet       = 1'b0;

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   binary_to_ascii_formatter_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   binary_to_ascii_formatter_checker text_check (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .fail_count    (fail_count),
      .chars_pending (chars_pending),
      .items_seen    (items_seen),
      .chars_seen    (chars_seen)
   );

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d characters outstanding",
                  cycle_count, chars_pending);
         $display("FAIL");
         $finish;
      end
   end

   // Back-pressure: after each accepted character drop tready for a randomly drawn stall, or none while quiet
   always @(posedge clock) begin
      int stall;
      if (reset) begin
         rsp_tready <= 1'b0;
         ready_hold <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         stall = quiet ? 0 : $urandom_range(3, 0);
         rsp_tready <= (stall == 0);
         ready_hold <= stall;
      end else if (ready_hold != 0) begin
         rsp_tready <= (ready_hold == 1);
         ready_hold <= ready_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Offer one item after a random gap and hold it until accepted
   task automatic send_item(input logic [CMD_W-1:0] fmt, input logic [VALUE_W-1:0] value);
      int gap;
      gap = quiet ? 0 : $urandom_range(3, 0);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= fmt;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Stop offering and wait until every expected character has arrived
   task automatic drain_text();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0) @(posedge clock);
   endtask

   // Mix of full random values, short numbers, powers of ten and near-max values
   function automatic logic [VALUE_W-1:0] draw_value();
      logic [VALUE_W-1:0] v;
      logic [31:0]        p;
      v = {$urandom, $urandom};
      case ($urandom_range(4, 0))
         2: v[31:0] = $urandom_range(120, 0);
         3: begin
            p = 32'd1;
            repeat ($urandom_range(9, 0)) p = p * 32'd10;
            v[31:0] = p + $urandom_range(2, 0) - 1;
         end
         4: v = 64'hFFFF_FFFF_FFFF_FFFF - $urandom_range(255, 0);
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      int                 n_fmt;
      logic [CMD_W-1:0]   fmt;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, every format, spare codes, zero, wide values
      send_item(FMT_HEX8,  64'h0);
      send_item(FMT_HEX8,  64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FMT_HEX8,  64'h1234_5678_9ABC_DE5A);
      send_item(FMT_HEX16, 64'h0);
      send_item(FMT_HEX16, 64'hFFFF);
      send_item(FMT_HEX16, 64'hFFFF_0000_0000_ABCD);
      send_item(FMT_HEX32, 64'h0);
      send_item(FMT_HEX32, 64'hFFFF_FFFF);
      send_item(FMT_HEX32, 64'hA5A5_A5A5_1234_5678);
      send_item(FMT_HEX64, 64'h0);
      send_item(FMT_HEX64, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FMT_HEX64, 64'h0123_4567_89AB_CDEF);
      send_item(FMT_HEX64, 64'hFEDC_BA98_7654_3210);
      send_item(FMT_DEC16, 64'h0);
      send_item(FMT_DEC16, 64'hFFFF);
      send_item(FMT_DEC16, 64'd1);
      send_item(FMT_DEC16, 64'd10000);
      send_item(FMT_DEC16, 64'hFFFF_FFFF_FFFF_0000);
      send_item(FMT_DEC32, 64'h0);
      send_item(FMT_DEC32, 64'hFFFF_FFFF);
      send_item(FMT_DEC32, 64'd1000000000);
      send_item(FMT_DEC32, 64'd999999999);
      send_item(FMT_DEC32, 64'hABCD_0000_0000_0001);
      send_item(FMT_SPARE_LO, 64'hFFFF_FFFF_FFFF_FFFF);
      send_item(FMT_SPARE_HI, 64'h0);
      drain_text();

      // Random: back-to-back stretch in the middle, one full drain later on
      n_fmt = 0;
      while (n_fmt < RANDOM_ITEMS) begin
         quiet <= (n_fmt >= 60 && n_fmt < 90);
         if ($urandom_range(15, 0) == 0) begin
            fmt = CMD_W'($urandom_range(FMT_SPARE_HI, FMT_SPARE_LO));
         end else begin
            fmt = CMD_W'($urandom_range(FMT_DEC32, FMT_HEX8));
         end
         send_item(fmt, draw_value());
         if (fmt <= FMT_DEC32) begin
            n_fmt++;
            if (n_fmt == 110) begin
               drain_text();
            end
         end
      end

      // Let the last text come out, then allow stray characters to show up
      drain_text();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Covered %0d items over all six formats plus the spare codes,",
               items_seen);
      $display("with %0d characters checked under random gaps and stalls.", chars_seen);
      if (fail_count == 0 && chars_pending == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
